// ===== sv/edfs_pkg.sv =====
// Shared types and constants of the EDF periodic task scheduler.
`default_nettype none

package edfs_pkg;

  // Field widths.
  localparam int CMD_W   = 3;
  localparam int SLOT_W  = 4;
  localparam int DL_W    = 48;
  localparam int PER_W   = 32;
  localparam int STAT_W  = 2;
  localparam int IN_W    = 88;
  localparam int OUT_W   = 16;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [1:0]        tstate_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [1:0]        alu_op_t;

  // Event codes.
  localparam cmd_t CMD_NEW   = 3'd0;
  localparam cmd_t CMD_TERM  = 3'd1;
  localparam cmd_t CMD_READY = 3'd2;
  localparam cmd_t CMD_BLOCK = 3'd3;
  localparam cmd_t CMD_DONE  = 3'd4;
  localparam cmd_t CMD_ACT   = 3'd5;

  // Task slot states.
  localparam tstate_t TS_FREE    = 2'd0;
  localparam tstate_t TS_ACTIVE  = 2'd1;
  localparam tstate_t TS_BLOCKED = 2'd2;
  localparam tstate_t TS_TIMED   = 2'd3;

  // Result status codes.
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NOT_USE = 2'd1;
  localparam status_t ST_IN_USE  = 2'd2;

  // Shared adder operations.
  localparam alu_op_t ALU_NOW_PIN  = 2'd0; // now + request period
  localparam alu_op_t ALU_NOW_PMEM = 2'd1; // now + stored period
  localparam alu_op_t ALU_DL_PMEM  = 2'd2; // stored deadline + stored period
  localparam alu_op_t ALU_CMP      = 2'd3; // candidate deadline - best deadline

endpackage

`default_nettype wire

// ===== sv/edfs_alu.sv =====
// Shared 48-bit adder used for deadline updates and for the deadline compare.
`default_nettype none

module edfs_alu (
  input  edfs_pkg::alu_op_t             op,
  input  logic [edfs_pkg::DL_W-1:0]     now,
  input  logic [edfs_pkg::PER_W-1:0]    period_in,
  input  logic [edfs_pkg::DL_W-1:0]     dl,
  input  logic [edfs_pkg::PER_W-1:0]    per,
  input  logic [edfs_pkg::DL_W-1:0]     best_dl,
  output logic [edfs_pkg::DL_W-1:0]     sum,
  output logic                          earlier
);
  import edfs_pkg::*;

  logic [DL_W-1:0] a;
  logic [DL_W-1:0] b;
  logic            cin;

  always_comb begin
    a   = dl;
    b   = DL_W'(per);
    cin = 1'b0;
    case (op)
      ALU_NOW_PIN: begin
        a = now;
        b = DL_W'(period_in);
      end
      ALU_NOW_PMEM: begin
        a = now;
        b = DL_W'(per);
      end
      ALU_DL_PMEM: begin
        a = dl;
        b = DL_W'(per);
      end
      ALU_CMP: begin
        a   = dl;
        b   = ~best_dl;
        cin = 1'b1;
      end
      default: begin
        a = dl;
        b = DL_W'(per);
      end
    endcase
  end

  assign sum = a + b + DL_W'(cin);

  // Serial order: the candidate is earlier when the wrapped difference is negative.
  assign earlier = sum[DL_W-1];

endmodule

`default_nettype wire

// ===== sv/edf_periodic_task_scheduler_top.sv =====
// Top level of the earliest-deadline-first periodic task scheduler.
`default_nettype none

// Each request carries one scheduling event (new, terminate, ready, block,
// work done or periodic activation) for one task slot, and produces exactly
// one result that reports the status of the event and any activate and
// suspend actions needed because the earliest-deadline active task changed.
// Deadlines are 48-bit tick counts compared in serial order, so they may wrap.
// The block works on one request at a time. The selection scan reads one
// slot's deadline per cycle from the deadline memory and feeds it through
// the single shared 48-bit adder that also computes the new deadlines.
// The result sits in an output register, so the next request can be taken
// while it waits; the block only holds in its final step when the previous
// result is still untaken. Slot numbers at or above SLOTS report "slot not
// in use". Deadline and period storage is not cleared by reset; only the
// slot states are.

module edf_periodic_task_scheduler_top #(
  parameter int SLOTS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // in_tdata fields from bit 0: cmd[2:0], slot[6:3], now[54:7], period[86:55]
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [edfs_pkg::IN_W-1:0]    in_tdata,
  // out_tdata fields from bit 0: status[1:0], accepted[2], activate_valid[3],
  // activate_slot[7:4], suspend_valid[8], suspend_slot[12:9], deadline_missed[13]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [edfs_pkg::OUT_W-1:0]   out_tdata
);
  import edfs_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_LAST  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]        state_r, state_nxt;

  // Request payload.
  cmd_t              cmd_r;
  logic [SLOT_W-1:0] slot_r;
  logic [DL_W-1:0]   now_r;
  logic [PER_W-1:0]  per_in_r;
  logic [SW-1:0]     slot_idx;
  logic              in_range;

  // Slot table.
  tstate_t           task_state_r [SLOTS];
  logic [DL_W-1:0]   dl_mem [SLOTS];
  logic [PER_W-1:0]  per_mem [SLOTS];
  logic [DL_W-1:0]   dl_q_r;
  logic [PER_W-1:0]  per_q_r;
  logic [SW-1:0]     rd_addr;
  logic              ts_we, dl_we, per_we;
  tstate_t           ts_wdata;
  tstate_t           cur_st;

  // Scan.
  logic [SW-1:0]     cnt_r, cnt_nxt;
  logic              cmp_v_r, cmp_v_nxt;
  logic [SW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic              cmp_act_r, cmp_act_nxt;
  logic              best_v_r, best_v_nxt;
  logic [SW-1:0]     best_idx_r, best_idx_nxt;
  logic [DL_W-1:0]   best_dl_r, best_dl_nxt;

  // Running task and result fields.
  logic              run_v_r, run_v_nxt;
  logic [SW-1:0]     run_slot_r, run_slot_nxt;
  status_t           status_r, status_nxt;
  logic              acc_r, acc_nxt;
  logic              miss_r, miss_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  // Shared adder.
  alu_op_t           alu_op;
  logic [DL_W-1:0]   alu_sum;
  logic              alu_earlier;

  logic              in_fire;
  logic              change;
  logic              act_v, sus_v;
  logic [SLOT_W-1:0] act_s, sus_s;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  assign slot_idx = SW'(slot_r);
  assign in_range = int'(slot_r) < SLOTS;
  assign cur_st   = task_state_r[slot_idx];
  assign rd_addr  = (state_r == S_SCAN) ? cnt_r : slot_idx;

  edfs_alu u_alu (
    .op        (alu_op),
    .now       (now_r),
    .period_in (per_in_r),
    .dl        (dl_q_r),
    .per       (per_q_r),
    .best_dl   (best_dl_r),
    .sum       (alu_sum),
    .earlier   (alu_earlier)
  );

  // Request payload capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= in_tdata[2:0];
      slot_r   <= in_tdata[6:3];
      now_r    <= in_tdata[54:7];
      per_in_r <= in_tdata[86:55];
    end
  end

  // Deadline and period memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (dl_we) begin
      dl_mem[slot_idx] <= alu_sum;
    end
    dl_q_r <= dl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (per_we) begin
      per_mem[slot_idx] <= per_in_r;
    end
    per_q_r <= per_mem[rd_addr];
  end

  // Slot states reset to free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        task_state_r[i] <= TS_FREE;
      end
    end else if (ts_we) begin
      task_state_r[slot_idx] <= ts_wdata;
    end
  end

  // Event update: decides status, slot state and deadline writes.
  always_comb begin
    ts_we      = 1'b0;
    ts_wdata   = TS_ACTIVE;
    dl_we      = 1'b0;
    per_we     = 1'b0;
    status_nxt = status_r;
    acc_nxt    = acc_r;
    miss_nxt   = miss_r;
    alu_op     = ALU_CMP;

    if (state_r == S_UPD) begin
      status_nxt = ST_OK;
      acc_nxt    = 1'b0;
      miss_nxt   = 1'b0;
      case (cmd_r)
        CMD_NEW:   alu_op = ALU_NOW_PIN;
        CMD_READY: alu_op = ALU_NOW_PMEM;
        default:   alu_op = ALU_DL_PMEM;
      endcase

      if (cmd_r <= CMD_ACT) begin
        if (!in_range) begin
          status_nxt = ST_NOT_USE;
        end else if (cmd_r == CMD_NEW) begin
          if (cur_st != TS_FREE) begin
            status_nxt = ST_IN_USE;
          end else begin
            ts_we    = 1'b1;
            ts_wdata = TS_ACTIVE;
            dl_we    = 1'b1;
            per_we   = 1'b1;
            acc_nxt  = 1'b1;
          end
        end else if (cur_st == TS_FREE) begin
          status_nxt = ST_NOT_USE;
        end else begin
          case (cmd_r)
            CMD_TERM: begin
              ts_we    = 1'b1;
              ts_wdata = TS_FREE;
            end
            CMD_READY: begin
              ts_we    = 1'b1;
              ts_wdata = TS_ACTIVE;
              dl_we    = 1'b1;
            end
            CMD_BLOCK: begin
              ts_we    = 1'b1;
              ts_wdata = TS_BLOCKED;
            end
            CMD_DONE: begin
              ts_we    = 1'b1;
              ts_wdata = TS_TIMED;
            end
            CMD_ACT: begin
              // A timed task is released; an active one has overrun its period.
              if (cur_st == TS_TIMED) begin
                ts_we    = 1'b1;
                ts_wdata = TS_ACTIVE;
                dl_we    = 1'b1;
              end else if (cur_st == TS_ACTIVE) begin
                dl_we    = 1'b1;
                miss_nxt = 1'b1;
              end
            end
            default: begin
              ts_we = 1'b0;
            end
          endcase
        end
      end
    end
  end

  // Decision: compare the pick against the running task.
  always_comb begin
    change = (best_v_r != run_v_r) || (best_v_r && (best_idx_r != run_slot_r));
    act_v  = change && best_v_r;
    act_s  = act_v ? SLOT_W'(best_idx_r) : '0;
    sus_v  = change && run_v_r && (task_state_r[run_slot_r] != TS_BLOCKED);
    sus_s  = sus_v ? SLOT_W'(run_slot_r) : '0;
  end

  // Sequencer, scan and result register.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cmp_v_nxt      = (state_r == S_SCAN);
    cmp_idx_nxt    = cnt_r;
    cmp_act_nxt    = (task_state_r[cnt_r] == TS_ACTIVE);
    best_v_nxt     = best_v_r;
    best_idx_nxt   = best_idx_r;
    best_dl_nxt    = best_dl_r;
    run_v_nxt      = run_v_r;
    run_slot_nxt   = run_slot_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;

    // Compare stage: the deadline read for cmp_idx_r arrives this cycle.
    if (cmp_v_r && cmp_act_r && (!best_v_r || alu_earlier)) begin
      best_v_nxt   = 1'b1;
      best_idx_nxt = cmp_idx_r;
      best_dl_nxt  = dl_q_r;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        // Terminating the running task drops it without a suspend.
        if (cmd_r == CMD_TERM && in_range && cur_st != TS_FREE &&
            run_v_r && run_slot_r == slot_idx) begin
          run_v_nxt    = 1'b0;
          run_slot_nxt = '0;
        end
        best_v_nxt = 1'b0;
        cnt_nxt    = '0;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + SW'(1);
        if (cnt_r == SW'(SLOTS - 1)) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = {2'b00, miss_r, sus_s, sus_v, act_s, act_v, acc_r, status_r};
          if (change) begin
            run_v_nxt    = best_v_r;
            run_slot_nxt = best_v_r ? best_idx_r : '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cmp_v_r      <= 1'b0;
      best_v_r     <= 1'b0;
      run_v_r      <= 1'b0;
      run_slot_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cmp_v_r      <= cmp_v_nxt;
      best_v_r     <= best_v_nxt;
      run_v_r      <= run_v_nxt;
      run_slot_r   <= run_slot_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    cmp_act_r  <= cmp_act_nxt;
    best_idx_r <= best_idx_nxt;
    best_dl_r  <= best_dl_nxt;
    status_r   <= status_nxt;
    acc_r      <= acc_nxt;
    miss_r     <= miss_nxt;
    out_data_r <= out_data_nxt;
  end

  // Between requests the running task is always an active slot.
  a_run_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && run_v_r) |-> (task_state_r[run_slot_r] == TS_ACTIVE))
    else $error("running task is not active while idle");

  // An activate and a suspend never name the same slot.
  a_act_sus_differ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_data_r[3] && out_data_r[8]) |-> (out_data_r[7:4] != out_data_r[12:9]))
    else $error("activate and suspend name the same slot");

  // An accepted new task always reports an ok status.
  a_acc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_data_r[2]) |-> (out_data_r[1:0] == ST_OK))
    else $error("accepted task with error status");

  // A missed deadline is only reported for an in-use slot.
  a_miss_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_data_r[13]) |-> (out_data_r[1:0] == ST_OK && !out_data_r[2]))
    else $error("deadline miss reported with error or acceptance");

  // An accepted request starts with the slot fetch.
  a_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_FETCH))
    else $error("request accepted without starting the sequence");

endmodule

`default_nettype wire
